[sv/spsm_pkg.sv]
`timescale 1ns / 1ps
// Package: sizes, op and status codes, controller/datapath command and status types
package spsm_pkg;

    localparam int MAX_SLOTS    = 1024;
    localparam int HEADER_BYTES = 8;
    localparam int SLOT_BYTES   = 4;
    localparam int PAGE_RESET   = 4096;

    localparam int FIELD_W   = 15;
    localparam int SLOT_IN_W = 16;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;
    localparam int SIDX_W    = 10;

    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int WORD_BITS = 32;
    localparam int WB_W      = $clog2(WORD_BITS);
    localparam int NWORDS    = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int IDX_W     = (CNT_W > WA_W + WB_W) ? CNT_W : WA_W + WB_W;
    localparam int DIR_MAX   = HEADER_BYTES + MAX_SLOTS * SLOT_BYTES;
    localparam int AV_W      = $clog2(DIR_MAX + 2 * (1 << FIELD_W)) + 1;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic              load;
        logic              dec;
        logic              scan_start;
        logic              scan_next;
        logic              scan_rd;
        logic              tgt_slot;
        logic              tgt_found;
        logic              tgt_append;
        logic              tgt_rd;
        logic              commit;
        logic              clear;
        logic              ok_next;
        logic              fail;
        logic [STAT_W-1:0] fail_code;
        logic              out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            no_room;
        logic            range_err;
        logic            next_oob;
        logic            found;
        logic            last_word;
        logic            tgt_bit;
        logic            app_fail;
    } t_stat;

endpackage

[sv/spsm_ctrl.sv]
`timescale 1ns / 1ps
// Controller: operation sequencer and output valid for the page space manager
module spsm_ctrl
    import spsm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_DEC  = 8'b0000_0010,
        S_SRD  = 8'b0000_0100,
        S_SCHK = 8'b0000_1000,
        S_APP  = 8'b0001_0000,
        S_TRD  = 8'b0010_0000,
        S_TACT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                cmd.dec = 1'b1;
                n_state = S_DONE;
                unique case (i_stat.op) inside
                    OP_INSERT: begin
                        if (i_stat.no_room) begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = ST_NO_SPACE;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SRD;
                        end
                    end
                    OP_DELETE, OP_GET: begin
                        if (i_stat.range_err) begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = ST_RANGE;
                        end else begin
                            cmd.tgt_slot = 1'b1;
                            n_state      = S_TRD;
                        end
                    end
                    OP_NEXT: begin
                        if (i_stat.next_oob) begin
                            cmd.fail      = 1'b1;
                            cmd.fail_code = ST_EMPTY;
                        end else begin
                            cmd.scan_start = 1'b1;
                            n_state        = S_SRD;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.clear = 1'b1;
                    end
                    default: begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = ST_RANGE;
                    end
                endcase
            end
            S_SRD: begin
                cmd.scan_rd = 1'b1;
                n_state     = S_SCHK;
            end
            S_SCHK: begin
                if (i_stat.found) begin
                    if (i_stat.op == OP_NEXT) begin
                        cmd.ok_next = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        cmd.tgt_found = 1'b1;
                        n_state       = S_TRD;
                    end
                end else if (i_stat.last_word) begin
                    if (i_stat.op == OP_NEXT) begin
                        cmd.fail      = 1'b1;
                        cmd.fail_code = ST_EMPTY;
                        n_state       = S_DONE;
                    end else begin
                        n_state = S_APP;
                    end
                end else begin
                    cmd.scan_next = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_APP: begin
                if (i_stat.app_fail) begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_NO_SPACE;
                    n_state       = S_DONE;
                end else begin
                    cmd.tgt_append = 1'b1;
                    n_state        = S_TRD;
                end
            end
            S_TRD: begin
                cmd.tgt_rd = 1'b1;
                n_state    = S_TACT;
            end
            S_TACT: begin
                n_state = S_DONE;
                if (i_stat.op != OP_INSERT && !i_stat.tgt_bit) begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = ST_EMPTY;
                end else begin
                    cmd.commit = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

[sv/spsm_dp.sv]
`timescale 1ns / 1ps
// Datapath: page state, slot directory memories, scan logic and result registers
module spsm_dp
    import spsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [FIELD_W-1:0]   i_cfg_wdata,
    input  logic [OP_W-1:0]      i_op,
    input  logic [SLOT_IN_W-1:0] i_slot,
    input  logic [FIELD_W-1:0]   i_record_length,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    output logic                 o_ok,
    output logic [STAT_W-1:0]    o_status,
    output logic [SIDX_W-1:0]    o_slot_index,
    output logic [FIELD_W-1:0]   o_record_offset,
    output logic [FIELD_W-1:0]   o_record_bytes,
    output logic [FIELD_W-1:0]   o_free_bytes
);

    // directory memories: used bits packed by word, record offset/length per slot
    logic [WORD_BITS-1:0] used_mem [NWORDS];
    logic [2*FIELD_W-1:0] rec_mem  [MAX_SLOTS];

    logic [OP_W-1:0]      r_op;
    logic [SLOT_IN_W-1:0] r_slot;
    logic [FIELD_W-1:0]   r_len;

    logic [FIELD_W-1:0]     r_page_bytes;
    logic [CNT_W-1:0]       r_slot_total;
    logic [FIELD_W-1:0]     r_free_start;
    logic signed [AV_W-1:0] r_avail;
    logic signed [AV_W-1:0] r_rem;

    logic [WA_W-1:0]      r_word;
    logic [IDX_W-1:0]     r_lo;
    logic [IDX_W-1:0]     r_target;
    logic                 r_append;
    logic [WORD_BITS-1:0] r_used_rd;
    logic [2*FIELD_W-1:0] r_rec_rd;

    logic                r_res_ok;
    logic [STAT_W-1:0]   r_res_status;
    logic [SIDX_W-1:0]   r_res_sidx;
    logic [FIELD_W-1:0]  r_res_roff;
    logic [FIELD_W-1:0]  r_res_rlen;

    logic signed [AV_W-1:0] rem;
    logic [SLOT_IN_W:0]     nstart;
    logic [SLOT_IN_W:0]     total_ext;
    logic [IDX_W-1:0]       lo_start;
    logic [IDX_W:0]         base;
    logic [WORD_BITS-1:0]   hit;
    logic [WB_W-1:0]        hit_pos;
    logic [IDX_W-1:0]       found_idx;
    logic                   want;
    logic [WA_W-1:0]        tgt_word;
    logic [WB_W-1:0]        tgt_pos;
    logic [SLOT_W-1:0]      tgt_addr;
    logic [FIELD_W-1:0]     new_fs;
    logic                   used_we;
    logic [WORD_BITS-1:0]   used_wdata;

    assign rem       = r_avail - $signed(AV_W'(r_len));
    assign nstart    = (r_slot == '1) ? '0 : (SLOT_IN_W+1)'(r_slot) + (SLOT_IN_W+1)'(1);
    assign total_ext = (SLOT_IN_W+1)'(r_slot_total);
    assign lo_start  = (r_op == OP_NEXT) ? IDX_W'(nstart) : '0;
    assign want      = (r_op == OP_NEXT);
    assign base      = (IDX_W+1)'(r_word) << WB_W;

    always_comb begin
        logic [IDX_W:0] idx;
        hit     = '0;
        hit_pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            idx    = base + (IDX_W+1)'(j);
            hit[j] = (idx >= (IDX_W+1)'(r_lo)) && (idx < (IDX_W+1)'(r_slot_total))
                     && (r_used_rd[j] == want);
        end
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (hit[j]) begin
                hit_pos = WB_W'(j);
            end
        end
    end

    assign found_idx = IDX_W'(base + (IDX_W+1)'(hit_pos));
    assign tgt_word  = r_target[WA_W+WB_W-1:WB_W];
    assign tgt_pos   = r_target[WB_W-1:0];
    assign tgt_addr  = r_target[SLOT_W-1:0];
    assign new_fs    = r_free_start - r_len;
    assign used_we   = i_cmd.commit && (r_op != OP_GET);

    always_comb begin
        used_wdata          = r_used_rd;
        used_wdata[tgt_pos] = (r_op == OP_INSERT);
    end

    assign o_stat.op        = r_op;
    assign o_stat.no_room   = rem < 0;
    assign o_stat.range_err = (SLOT_IN_W+1)'(r_slot) >= total_ext;
    assign o_stat.next_oob  = nstart >= total_ext;
    assign o_stat.found     = |hit;
    assign o_stat.last_word = (base + (IDX_W+1)'(WORD_BITS)) >= (IDX_W+1)'(r_slot_total);
    assign o_stat.tgt_bit   = r_used_rd[tgt_pos];
    assign o_stat.app_fail  = (r_rem < $signed(AV_W'(SLOT_BYTES)))
                              || (r_slot_total >= CNT_W'(MAX_SLOTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_used_rd <= used_mem[r_word];
        end else if (i_cmd.tgt_rd) begin
            r_used_rd <= used_mem[tgt_word];
        end
        if (used_we) begin
            used_mem[tgt_word] <= used_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_rd) begin
            r_rec_rd <= rec_mem[tgt_addr];
        end
        if (i_cmd.commit && r_op == OP_INSERT) begin
            rec_mem[tgt_addr] <= {new_fs, r_len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_bytes <= FIELD_W'(PAGE_RESET);
            r_slot_total <= '0;
            r_free_start <= FIELD_W'(PAGE_RESET);
            r_avail      <= AV_W'(PAGE_RESET - HEADER_BYTES);
        end else begin
            if (i_cfg_we) begin
                r_page_bytes <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_slot_total <= '0;
                r_free_start <= r_page_bytes;
                r_avail      <= $signed(AV_W'(r_page_bytes)) - $signed(AV_W'(HEADER_BYTES));
            end else if (i_cmd.commit && r_op == OP_INSERT) begin
                r_free_start <= new_fs;
                if (r_append) begin
                    r_slot_total <= r_slot_total + CNT_W'(1);
                    r_avail      <= r_rem - $signed(AV_W'(SLOT_BYTES));
                end else begin
                    r_avail <= r_rem;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_slot <= i_slot;
            r_len  <= i_record_length;
        end
        if (i_cmd.dec) begin
            r_rem <= rem;
        end
        if (i_cmd.scan_start) begin
            r_lo   <= lo_start;
            r_word <= lo_start[WA_W+WB_W-1:WB_W];
        end else if (i_cmd.scan_next) begin
            r_word <= r_word + WA_W'(1);
        end
        if (i_cmd.tgt_slot) begin
            r_target <= IDX_W'(r_slot);
        end else if (i_cmd.tgt_found) begin
            r_target <= found_idx;
        end else if (i_cmd.tgt_append) begin
            r_target <= IDX_W'(r_slot_total);
        end
        if (i_cmd.tgt_slot || i_cmd.tgt_found || i_cmd.tgt_append) begin
            r_append <= i_cmd.tgt_append;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fail) begin
            r_res_ok     <= 1'b0;
            r_res_status <= i_cmd.fail_code;
            r_res_sidx   <= '0;
            r_res_roff   <= '0;
            r_res_rlen   <= '0;
        end else if (i_cmd.clear) begin
            r_res_ok     <= 1'b1;
            r_res_status <= ST_OK;
            r_res_sidx   <= '0;
            r_res_roff   <= '0;
            r_res_rlen   <= '0;
        end else if (i_cmd.ok_next) begin
            r_res_ok     <= 1'b1;
            r_res_status <= ST_OK;
            r_res_sidx   <= SIDX_W'(found_idx);
            r_res_roff   <= '0;
            r_res_rlen   <= '0;
        end else if (i_cmd.commit) begin
            r_res_ok     <= 1'b1;
            r_res_status <= ST_OK;
            r_res_sidx   <= '0;
            r_res_roff   <= '0;
            r_res_rlen   <= '0;
            if (r_op == OP_INSERT) begin
                r_res_sidx <= SIDX_W'(r_target);
                r_res_roff <= new_fs;
                r_res_rlen <= r_len;
            end else if (r_op == OP_GET) begin
                r_res_roff <= r_rec_rd[2*FIELD_W-1:FIELD_W];
                r_res_rlen <= r_rec_rd[FIELD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_ok            <= r_res_ok;
            o_status        <= r_res_status;
            o_slot_index    <= r_res_sidx;
            o_record_offset <= r_res_roff;
            o_record_bytes  <= r_res_rlen;
            o_free_bytes    <= (r_avail < 0) ? '0 : r_avail[FIELD_W-1:0];
        end
    end

endmodule

[sv/slotted_page_space_manager_top.sv]
`timescale 1ns / 1ps
// Top level: slot directory manager of one slotted database page
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  in       | in        | i_in_valid / o_in_stall   | i_op, i_slot, i_record_length
//  out      | out       | o_out_valid / i_out_stall | o_ok, o_status, o_slot_index,
//           |           |                           | o_record_offset, o_record_bytes,
//           |           |                           | o_free_bytes
//  cfg      | in        | i_cfg_we                  | i_cfg_wdata (page size)
//
// One item at a time. Delete and get go straight to the target slot; clear and early failures
// finish at decode. Insert and next-occupied scan the used bits one 32-slot word at a time.
// Reset is synchronous; no clearing pass, directory memories are valid below slot_total.
// A result held by i_out_stall does not block the next transfer on the input side.
module slotted_page_space_manager_top
    import spsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [FIELD_W-1:0]   i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [OP_W-1:0]      i_op,
    input  logic [SLOT_IN_W-1:0] i_slot,
    input  logic [FIELD_W-1:0]   i_record_length,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_ok,
    output logic [STAT_W-1:0]    o_status,
    output logic [SIDX_W-1:0]    o_slot_index,
    output logic [FIELD_W-1:0]   o_record_offset,
    output logic [FIELD_W-1:0]   o_record_bytes,
    output logic [FIELD_W-1:0]   o_free_bytes
);

    t_cmd  cmd;
    t_stat stat;

    spsm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    spsm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_op),
        .i_slot          (i_slot),
        .i_record_length (i_record_length),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_ok            (o_ok),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_record_offset (o_record_offset),
        .o_record_bytes  (o_record_bytes),
        .o_free_bytes    (o_free_bytes)
    );

endmodule

[sv/spsm_chk.sv]
`timescale 1ns / 1ps
// Checker: port-level properties of the page space manager, bound to the top level
module spsm_chk
    import spsm_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_ok,
    input logic [STAT_W-1:0]    o_status,
    input logic [SIDX_W-1:0]    o_slot_index,
    input logic [FIELD_W-1:0]   o_record_offset,
    input logic [FIELD_W-1:0]   o_record_bytes
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ok == (o_status == ST_OK)))
        else $error("ok flag disagrees with status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |->
            o_slot_index == '0 && o_record_offset == '0 && o_record_bytes == '0)
        else $error("failed result carries data");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transfer taken while busy");

endmodule

bind slotted_page_space_manager_top spsm_chk u_chk (.*);

[bench/slotted_page_space_manager_top_tb.sv]
`timescale 1ns / 1ps
// Testbench: slot directory manager checked against a cycle-free page directory predictor
module slotted_page_space_manager_top_tb;
    import spsm_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [SLOT_IN_W-1:0] SCAN_FROM_START = '1;
    localparam int OP_LAST = (1 << OP_W) - 1;

    typedef struct packed {
        logic               ok;
        logic [STAT_W-1:0]  status;
        logic [SIDX_W-1:0]  slot_index;
        logic [FIELD_W-1:0] record_offset;
        logic [FIELD_W-1:0] record_bytes;
        logic [FIELD_W-1:0] free_bytes;
    } t_page_result;

    class page_directory_checker;
        logic [FIELD_W-1:0] page_bytes;
        int                 slot_total;
        int                 free_start;
        logic [FIELD_W-1:0] slot_offset [MAX_SLOTS];
        logic [FIELD_W-1:0] slot_length [MAX_SLOTS];
        bit                 slot_used   [MAX_SLOTS];
        t_page_result       expected_results[$];
        int                 errors;
        int                 requests;
        int                 compared;
        int                 peak_slots;

        function new();
            page_bytes = FIELD_W'(PAGE_RESET);
            slot_total = 0;
            free_start = PAGE_RESET;
            errors     = 0;
            requests   = 0;
            compared   = 0;
            peak_slots = 0;
        endfunction

        function int free_space();
            return free_start - (HEADER_BYTES + slot_total * SLOT_BYTES);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [SLOT_IN_W-1:0] slot,
                                   logic [FIELD_W-1:0] len);
            t_page_result r;
            int           avail;
            int           i;
            r       = '0;
            r.status = ST_OK;
            case (op)
                OP_INSERT: begin
                    avail = free_space();
                    if (avail < int'(len)) begin
                        r.status = ST_NO_SPACE;
                    end else begin
                        for (i = 0; i < slot_total; i++)
                            if (!slot_used[i]) break;
                        if (i >= slot_total &&
                            (avail - int'(len) < SLOT_BYTES || slot_total >= MAX_SLOTS)) begin
                            r.status = ST_NO_SPACE;
                        end else begin
                            if (i >= slot_total) begin
                                i = slot_total;
                                slot_total++;
                            end
                            free_start     = free_start - int'(len);
                            slot_offset[i] = FIELD_W'(free_start);
                            slot_length[i] = len;
                            slot_used[i]   = 1'b1;
                            r.ok            = 1'b1;
                            r.slot_index    = SIDX_W'(i);
                            r.record_offset = FIELD_W'(free_start);
                            r.record_bytes  = len;
                        end
                    end
                end
                OP_DELETE, OP_GET: begin
                    if (int'(slot) >= slot_total) begin
                        r.status = ST_RANGE;
                    end else if (!slot_used[slot]) begin
                        r.status = ST_EMPTY;
                    end else begin
                        if (op == OP_DELETE) begin
                            slot_used[slot] = 1'b0;
                        end else begin
                            r.record_offset = slot_offset[slot];
                            r.record_bytes  = slot_length[slot];
                        end
                        r.ok = 1'b1;
                    end
                end
                OP_NEXT: begin
                    i = (slot == SCAN_FROM_START) ? 0 : int'(slot) + 1;
                    for (; i < slot_total; i++)
                        if (slot_used[i]) break;
                    if (i < slot_total) begin
                        r.ok         = 1'b1;
                        r.slot_index = SIDX_W'(i);
                    end else begin
                        r.status = ST_EMPTY;
                    end
                end
                OP_CLEAR: begin
                    slot_total = 0;
                    free_start = int'(page_bytes);
                    r.ok       = 1'b1;
                end
                default: r.status = ST_RANGE;
            endcase
            avail = free_space();
            r.free_bytes = FIELD_W'((avail < 0) ? 0 : avail);
            if (slot_total > peak_slots) peak_slots = slot_total;
            requests++;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_page_result got);
            t_page_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compared++;
            compare_field("ok", want.ok, got.ok);
            compare_field("status", want.status, got.status);
            compare_field("slot_index", want.slot_index, got.slot_index);
            compare_field("record_offset", want.record_offset, got.record_offset);
            compare_field("record_bytes", want.record_bytes, got.record_bytes);
            compare_field("free_bytes", want.free_bytes, got.free_bytes);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [FIELD_W-1:0]   i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op = OP_INSERT;
    logic [SLOT_IN_W-1:0] i_slot = '0;
    logic [FIELD_W-1:0]   i_record_length = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_ok;
    logic [STAT_W-1:0]    o_status;
    logic [SIDX_W-1:0]    o_slot_index;
    logic [FIELD_W-1:0]   o_record_offset;
    logic [FIELD_W-1:0]   o_record_bytes;
    logic [FIELD_W-1:0]   o_free_bytes;

    page_directory_checker sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;

    slotted_page_space_manager_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_slot          (i_slot),
        .i_record_length (i_record_length),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ok            (o_ok),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_record_offset (o_record_offset),
        .o_record_bytes  (o_record_bytes),
        .o_free_bytes    (o_free_bytes)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: check on each transfer, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result({o_ok, o_status, o_slot_index, o_record_offset,
                                 o_record_bytes, o_free_bytes});
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [SLOT_IN_W-1:0] slot,
                                logic [FIELD_W-1:0] len);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_slot          <= slot;
        i_record_length <= len;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(op, slot, len);
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // page size takes effect at the next clear
    task automatic set_page(int unsigned bytes);
        wait_for_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= FIELD_W'(bytes);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.page_bytes = FIELD_W'(bytes);
        send_request(OP_CLEAR, '0, '0);
    endtask

    function automatic logic [SLOT_IN_W-1:0] pick_slot();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return SLOT_IN_W'($urandom_range(0, sb.slot_total));
        if (r < 88) return SCAN_FROM_START;
        return SLOT_IN_W'($urandom);
    endfunction

    task automatic random_request();
        int                 r;
        int                 span;
        logic [FIELD_W-1:0] len;
        r    = $urandom_range(0, 99);
        span = int'(sb.page_bytes) / 6;
        if (span < 8) span = 8;
        len = ($urandom_range(0, 9) == 0) ? FIELD_W'($urandom) : FIELD_W'($urandom_range(0, span));
        if (r < 38)      send_request(OP_INSERT, SLOT_IN_W'($urandom), len);
        else if (r < 53) send_request(OP_DELETE, pick_slot(), len);
        else if (r < 71) send_request(OP_GET, pick_slot(), len);
        else if (r < 86) send_request(OP_NEXT, pick_slot(), len);
        else if (r < 91) send_request(OP_CLEAR, pick_slot(), len);
        else if (r < 94) send_request(OP_W'($urandom_range(OP_CLEAR + 1, OP_LAST)), pick_slot(), len);
        else             send_request(OP_INSERT, pick_slot(), FIELD_W'($urandom));
    endtask

    function automatic int unsigned pick_page();
        case ($urandom_range(0, 7))
            0:       return 64;
            1:       return 32767;
            2:       return 4096;
            3:       return $urandom_range(0, 32767);
            default: return $urandom_range(64, 700);
        endcase
    endfunction

    task automatic random_phase(int chunks);
        for (int c = 0; c < chunks; c++) begin
            set_page(pick_page());
            for (int k = 0; k < 50; k++) random_request();
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty page, reuse of freed slots, exact fit, bad ops
        send_request(OP_GET, '0, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_NEXT, SCAN_FROM_START, '0);
        send_request(OP_INSERT, '0, '0);
        send_request(OP_INSERT, '0, 15'd100);
        send_request(OP_INSERT, '0, '1);
        send_request(OP_GET, 16'd1, '0);
        send_request(OP_DELETE, '0, '0);
        send_request(OP_GET, '0, '0);
        send_request(OP_NEXT, SCAN_FROM_START, '0);
        send_request(OP_NEXT, 16'd1, '0);
        send_request(OP_NEXT, 16'hFFFE, '0);
        send_request(OP_INSERT, '0, 15'd50);
        send_request(OP_GET, SCAN_FROM_START, '0);
        for (int o = OP_CLEAR + 1; o <= OP_LAST; o++) send_request(OP_W'(o), '1, '1);
        wait_for_results();
        send_request(OP_INSERT, '0, FIELD_W'(sb.free_space() - SLOT_BYTES));
        send_request(OP_INSERT, '0, '0);
        send_request(OP_DELETE, 16'd2, '0);
        send_request(OP_INSERT, '0, '0);
        set_page(0);
        send_request(OP_INSERT, '0, '0);
        set_page(4);
        send_request(OP_INSERT, '0, '0);
        set_page(32767);
        send_request(OP_INSERT, '0, '1);

        send_idle_pct = 7;
        recv_idle_pct = 85;
        random_phase(1);
        send_idle_pct = 85;
        recv_idle_pct = 7;
        random_phase(1);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // fill the directory to its slot limit on the largest page
        set_page(32767);
        while (sb.slot_total < MAX_SLOTS) begin
            send_request(OP_INSERT, '0, FIELD_W'($urandom_range(0, 24)));
        end
        wait_for_results();
        repeat (4) send_request(OP_INSERT, '0, FIELD_W'($urandom_range(0, 24)));
        send_request(OP_DELETE, SLOT_IN_W'($urandom_range(0, MAX_SLOTS - 1)), '0);
        send_request(OP_INSERT, '0, 15'd3);
        send_request(OP_NEXT, SLOT_IN_W'(MAX_SLOTS - 2), '0);
        send_request(OP_NEXT, SLOT_IN_W'(MAX_SLOTS - 1), '0);
        send_request(OP_GET, SLOT_IN_W'(MAX_SLOTS - 1), '0);
        send_request(OP_GET, SLOT_IN_W'(MAX_SLOTS), '0);
        for (int k = 0; k < 40; k++) random_request();

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d results compared, peak directory %0d slots,",
                 sb.requests, sb.compared, sb.peak_slots);
        $display("page sizes from 0 to 32767 with idling on either side and none.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
